[design/rcts_pkg.sv]
// Shared types and constants of the raycast column texture shader.
`default_nettype none
package rcts_pkg;

  localparam int SCREEN_WIDTH    = 1024;
  localparam int SCREEN_HEIGHT   = 768;
  localparam int TEX_MAX_DIM_DEF = 64;

  localparam logic [31:0] MAGENTA = 32'h00FF00FF;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_SHADE = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [1:0] REG_CEILING_COLOR = 2'd0;
  localparam logic [1:0] REG_FLOOR_COLOR   = 2'd1;
  localparam logic [1:0] REG_TEX_WIDTH     = 2'd2;
  localparam logic [1:0] REG_TEX_HEIGHT    = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               side;
    logic               facing_positive;
    logic signed [11:0] draw_start;
    logic signed [11:0] draw_stop;
    logic signed [7:0]  tex_column;
    logic signed [31:0] tex_pos_init;
    logic [30:0]        pos_step;
    logic [9:0]         row;
    logic [9:0]         col;
    logic [11:0]        texel_index;
    logic [31:0]        texel_data;
  } item_t;

  typedef struct packed {
    logic [19:0] frame_address;
    logic [31:0] pixel_color;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic        use_texel;
    logic [19:0] frame_address;
    logic [31:0] color;
  } shade_t;

endpackage
`default_nettype wire

[design/rcts_texel_mem.sv]
// Texel memory: one write port, one registered read port with enable.
`default_nettype none
module rcts_texel_mem #(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [31:0]       wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]            rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[design/rcts_front.sv]
// Column state, configuration registers, span test and texel address generation.
`default_nettype none
module rcts_front import rcts_pkg::*; #(
  parameter  int TEX_MAX_DIM = TEX_MAX_DIM_DEF,
  localparam int TEX_SLOT    = TEX_MAX_DIM * TEX_MAX_DIM,
  localparam int ADDR_W      = $clog2(4 * TEX_SLOT)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              accept,
  input  wire item_t             item,
  output shade_t                 shade,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [31:0]            wr_data,
  output logic [ADDR_W-1:0]      rd_addr
);

  logic [3:0]         loaded;
  logic [1:0]         sel;
  logic signed [11:0] span_start;
  logic signed [11:0] span_stop;
  logic signed [7:0]  column_texel;
  logic signed [31:0] acc;
  logic [30:0]        step;
  logic [31:0]        ceiling_color;
  logic [31:0]        floor_color;
  logic [6:0]         tex_width;
  logic [6:0]         tex_height;

  logic               on_screen;
  logic               is_shade;
  logic signed [12:0] row_s;
  logic signed [12:0] start_x;
  logic signed [12:0] stop_x;
  logic               above;
  logic               below;
  logic [6:0]         w_sat;
  logic [6:0]         h_sat;
  logic               empty;
  logic [14:0]        ty_raw;
  logic [6:0]         ty;
  logic [6:0]         tx_raw;
  logic [6:0]         tx;
  logic [13:0]        offset;
  logic               use_texel;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_next;
  logic [1:0]         code;

  assign on_screen = (32'(item.row) < SCREEN_HEIGHT) && (32'(item.col) < SCREEN_WIDTH);
  assign is_shade  = accept && (item.cmd == CMD_SHADE) && on_screen;

  assign row_s   = {3'b000, item.row};
  assign start_x = {span_start[11], span_start};
  assign stop_x  = {span_stop[11], span_stop};
  assign above   = row_s < start_x;
  assign below   = row_s > stop_x;

  assign w_sat = (32'(tex_width) > TEX_MAX_DIM) ? 7'(TEX_MAX_DIM) : tex_width;
  assign h_sat = (32'(tex_height) > TEX_MAX_DIM) ? 7'(TEX_MAX_DIM) : tex_height;
  assign empty = !loaded[sel] || (w_sat == 7'd0) || (h_sat == 7'd0);

  assign ty_raw = acc[31] ? 15'd0 : acc[30:16];
  assign ty     = (ty_raw >= {8'd0, h_sat}) ? h_sat - 7'd1 : ty_raw[6:0];
  assign tx_raw = column_texel[7] ? 7'd0 : column_texel[6:0];
  assign tx     = (tx_raw >= w_sat) ? w_sat - 7'd1 : tx_raw;
  assign offset = 14'(ty) * 14'(w_sat) + 14'(tx);
  assign rd_addr = ADDR_W'(32'(sel) * TEX_SLOT + 32'(offset));

  assign use_texel = is_shade && !above && !below && !empty;

  assign acc_sum  = {acc[31], acc} + {2'b00, step};
  assign acc_next = (!acc_sum[32] && acc_sum[31]) ? 32'sh7FFFFFFF : acc_sum[31:0];

  assign code    = {item.side, item.facing_positive};
  assign wr_en   = accept && (item.cmd == CMD_LOAD) && (32'(item.texel_index) < TEX_SLOT);
  assign wr_addr = ADDR_W'(32'(code) * TEX_SLOT + 32'(item.texel_index));
  assign wr_data = item.texel_data;

  always_comb begin
    shade.valid         = is_shade;
    shade.use_texel     = use_texel;
    shade.frame_address = 20'(32'(item.row) * SCREEN_WIDTH + 32'(item.col));
    if (above) begin
      shade.color = ceiling_color;
    end else if (below) begin
      shade.color = floor_color;
    end else begin
      shade.color = MAGENTA;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded        <= '0;
      sel           <= '0;
      span_start    <= '0;
      span_stop     <= '0;
      column_texel  <= '0;
      acc           <= '0;
      step          <= '0;
      ceiling_color <= '0;
      floor_color   <= '0;
      tex_width     <= 7'd64;
      tex_height    <= 7'd64;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CEILING_COLOR: ceiling_color <= cfg_data;
          REG_FLOOR_COLOR:   floor_color   <= cfg_data;
          REG_TEX_WIDTH:     tex_width     <= cfg_data[6:0];
          REG_TEX_HEIGHT:    tex_height    <= cfg_data[6:0];
        endcase
      end
      if (accept && (item.cmd == CMD_BEGIN)) begin
        sel          <= code;
        span_start   <= item.draw_start;
        span_stop    <= item.draw_stop;
        column_texel <= item.tex_column;
        acc          <= item.tex_pos_init;
        step         <= item.pos_step;
      end
      if (use_texel) begin
        acc <= acc_next;
      end
      if (wr_en) begin
        loaded[code] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[design/rcts_out_stage.sv]
// Read-wait stage and output register with flow control.
`default_nettype none
module rcts_out_stage import rcts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire shade_t      shade,
  input  wire logic [31:0] texel,
  output logic             hold,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result
);

  logic        s1_valid;
  logic        s1_use_texel;
  logic [19:0] s1_address;
  logic [31:0] s1_color;
  logic        advance;

  assign advance = !result_valid || !result_stall;
  assign hold    = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!s1_valid || advance) begin
        s1_valid <= shade.valid;
      end
      if (advance) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_valid || advance) begin
      s1_use_texel <= shade.use_texel;
      s1_address   <= shade.frame_address;
      s1_color     <= shade.color;
    end
    if (advance) begin
      result.frame_address <= s1_address;
      result.pixel_color   <= s1_use_texel ? texel : s1_color;
    end
  end

endmodule
`default_nettype wire

[design/raycast_column_texture_shader.sv]
// Top level of the raycast column texture shader.
//
// Input channel item_valid / item_stall / item carries one command per
// transaction: begin column, shade pixel or load texel. Only an on-screen
// shade command produces a transaction on result_valid / result_stall /
// result, which carries the framebuffer word address and its color.
// Configuration registers (ceiling color, floor color, texture width and
// height) are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, as the block itself does not enforce it.
// Throughput is one command per cycle while item_stall is low, set by the single
// texel memory read port that each wall pixel uses once. A shade command passes
// the texel memory read with the read-wait stage, then the output register.
// Reset clears the column state and the texture loaded flags and returns the
// configuration registers to their reset values; texel contents stay
// undefined until loaded.
// While the receiver stalls, the output register holds its transaction and
// one more shade result waits in the read stage; item_stall rises only once
// both are full.
`default_nettype none
module raycast_column_texture_shader import rcts_pkg::*; #(
  parameter  int TEX_MAX_DIM = TEX_MAX_DIM_DEF,
  localparam int TEX_SLOT    = TEX_MAX_DIM * TEX_MAX_DIM,
  localparam int ADDR_W      = $clog2(4 * TEX_SLOT)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output result_t          result
);

  logic              accept;
  shade_t            shade;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       texel;

  assign accept = item_valid && !item_stall;

  rcts_front #(
    .TEX_MAX_DIM(TEX_MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item),
    .shade    (shade),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr)
  );

  rcts_texel_mem #(
    .DEPTH (4 * TEX_SLOT),
    .ADDR_W(ADDR_W)
  ) u_texel_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (shade.use_texel),
    .rd_addr(rd_addr),
    .rd_data(texel)
  );

  rcts_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .shade       (shade),
    .texel       (texel),
    .hold        (item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule
`default_nettype wire

[tb/raycast_column_texture_shader_tb.sv]
// Self-checking testbench for the raycast column texture shader: directed table, random columns.
`timescale 1ns / 1ps
module raycast_column_texture_shader_tb;
  import rcts_pkg::*;

  localparam int TEX_SLOT = TEX_MAX_DIM_DEF * TEX_MAX_DIM_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 275;

  typedef struct {
    item_t       it;
    bit          fixed;
    logic [31:0] color;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;

  raycast_column_texture_shader uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  logic [31:0]        ceil_rgb = '0;
  logic [31:0]        floor_rgb = '0;
  logic [6:0]         tex_w = 7'd64;
  logic [6:0]         tex_h = 7'd64;
  logic [31:0]        texel_mem [4*TEX_SLOT];
  bit                 texel_written [4*TEX_SLOT];
  logic [3:0]         tex_loaded = '0;
  logic [1:0]         tex_sel = '0;
  logic signed [11:0] span_lo = '0;
  logic signed [11:0] span_hi = '0;
  logic signed [7:0]  col_texel = '0;
  logic signed [31:0] row_pos = '0;
  logic [30:0]        row_step = '0;

  result_t expected_pixels[$];
  result_t got_px;
  result_t want_px;
  int      mismatches = 0;
  int      commands_sent = 0;
  int      cycles = 0;
  int      stall_left = 0;
  bit      steady_rx = 0;
  bit      steady_tx = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("raycast_column_texture_shader_tb NOT OK");
      $finish;
    end
  end

  function automatic item_t rand_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t shade_cmd(int r, int c);
    item_t it;
    it = rand_item();
    it.cmd = CMD_SHADE;
    it.row = 10'(r);
    it.col = 10'(c);
    return it;
  endfunction

  function automatic item_t load_cmd(logic [1:0] code, int idx, logic [31:0] data);
    item_t it;
    it = rand_item();
    it.cmd = CMD_LOAD;
    {it.side, it.facing_positive} = code;
    it.texel_index = 12'(idx);
    it.texel_data = data;
    return it;
  endfunction

  function automatic item_t begin_cmd(logic [1:0] code, int lo, int hi, int tcol,
                                      logic [31:0] pos, logic [30:0] stp);
    item_t it;
    it = rand_item();
    it.cmd = CMD_BEGIN;
    {it.side, it.facing_positive} = code;
    it.draw_start = 12'(lo);
    it.draw_stop = 12'(hi);
    it.tex_column = 8'(tcol);
    it.tex_pos_init = pos;
    it.pos_step = stp;
    return it;
  endfunction

  function automatic stim_row_t table_row(item_t it, bit fixed, logic [31:0] c);
    stim_row_t s;
    s.it = it;
    s.fixed = fixed;
    s.color = c;
    return s;
  endfunction

  function automatic int eff_dim(logic [6:0] d);
    return (d > TEX_MAX_DIM_DEF) ? TEX_MAX_DIM_DEF : int'(d);
  endfunction

  function automatic bit on_screen(item_t it);
    return it.row < SCREEN_HEIGHT && it.col < SCREEN_WIDTH;
  endfunction

  // -1 when the wall pixel reads no texel (magenta case)
  function automatic int wall_texel_addr();
    int w;
    int h;
    int tx;
    int ty;
    w = eff_dim(tex_w);
    h = eff_dim(tex_h);
    if (!tex_loaded[tex_sel] || w == 0 || h == 0) return -1;
    ty = (row_pos < 0) ? 0 : int'(row_pos[31:16]);
    if (ty >= h) ty = h - 1;
    tx = (col_texel < 0) ? 0 : int'(col_texel);
    if (tx >= w) tx = w - 1;
    return int'(tex_sel) * TEX_SLOT + (ty * w + tx) % TEX_SLOT;
  endfunction

  task automatic predict_pixel(input item_t it);
    int          a;
    int          r;
    logic [31:0] color;
    longint      nxt;
    result_t     px;
    case (it.cmd)
      CMD_BEGIN: begin
        tex_sel = {it.side, it.facing_positive};
        span_lo = it.draw_start;
        span_hi = it.draw_stop;
        col_texel = it.tex_column;
        row_pos = it.tex_pos_init;
        row_step = it.pos_step;
      end
      CMD_LOAD: begin
        if (it.texel_index < TEX_SLOT) begin
          a = int'({it.side, it.facing_positive}) * TEX_SLOT + int'(it.texel_index);
          texel_mem[a] = it.texel_data;
          texel_written[a] = 1'b1;
          tex_loaded[{it.side, it.facing_positive}] = 1'b1;
        end
      end
      CMD_SHADE: begin
        if (on_screen(it)) begin
          r = int'(it.row);
          if (r < span_lo) begin
            color = ceil_rgb;
          end else if (r > span_hi) begin
            color = floor_rgb;
          end else begin
            a = wall_texel_addr();
            if (a < 0) begin
              color = MAGENTA;
            end else begin
              color = texel_mem[a];
              nxt = longint'(row_pos) + longint'(row_step);
              row_pos = (nxt > 64'sh7FFFFFFF) ? 32'h7FFFFFFF : nxt[31:0];
            end
          end
          px.frame_address = 20'(int'(it.row) * SCREEN_WIDTH + int'(it.col));
          px.pixel_color = color;
          expected_pixels.push_back(px);
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input item_t it);
    int gap;
    int r;
    if ($urandom_range(0, 49) == 0) steady_tx = !steady_tx;
    gap = 0;
    if (!steady_tx) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(6, 30);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_pixel(it);
    if (it.cmd != CMD_UNUSED) commands_sent++;
  endtask

  // load a never-written texel first so a wall read always hits written data
  task automatic issue(input item_t it);
    int    a;
    int    r;
    item_t fill;
    r = int'(it.row);
    if (it.cmd == CMD_SHADE && on_screen(it) && r >= span_lo && r <= span_hi) begin
      a = wall_texel_addr();
      if (a >= 0 && !texel_written[a]) begin
        fill = load_cmd(2'(a / TEX_SLOT), a % TEX_SLOT, $urandom);
        push_item(fill);
      end
    end
    push_item(it);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CEILING_COLOR: ceil_rgb = data;
      REG_FLOOR_COLOR:   floor_rgb = data;
      REG_TEX_WIDTH:     tex_w = data[6:0];
      REG_TEX_HEIGHT:    tex_h = data[6:0];
      default: ;
    endcase
  endtask

  task automatic run_column();
    item_t it;
    int    n;
    int    r0;
    int    c;
    it = rand_item();
    it.cmd = CMD_BEGIN;
    if ($urandom_range(0, 9) != 0) begin
      it.draw_start = 12'($urandom_range(0, 400) - 60);
      it.draw_stop = 12'(int'(it.draw_start) + $urandom_range(0, 450) - 10);
    end
    if ($urandom_range(0, 3) != 0) it.tex_column = 8'($urandom_range(0, 80) - 8);
    if ($urandom_range(0, 4) != 0) it.tex_pos_init = $urandom_range(0, 40 << 16) - (4 << 16);
    if ($urandom_range(0, 4) != 0) it.pos_step = 31'($urandom_range(0, 3 << 16));
    issue(it);
    n = $urandom_range(1, 40);
    r0 = $urandom_range(0, 760);
    c = $urandom_range(0, 1023);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) issue(shade_cmd($urandom_range(0, 1023), c));
      else issue(shade_cmd(r0 + i, c));
    end
  endtask

  task automatic random_step();
    int    r;
    int    n;
    item_t it;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        it = load_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 4095), $urandom);
        if ($urandom_range(0, 1) == 0) it.texel_index = 12'($urandom_range(0, 255));
        issue(it);
      end
    end else if (r < 16) begin
      issue(rand_item());
    end else begin
      run_column();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got_px = result;
      if (expected_pixels.size() == 0) begin
        $error("unexpected transaction: frame_address %0d pixel_color %h",
               got_px.frame_address, got_px.pixel_color);
        mismatches++;
      end else begin
        want_px = expected_pixels.pop_front();
        if (got_px.frame_address !== want_px.frame_address) begin
          $error("frame_address expected %0d actual %0d",
                 want_px.frame_address, got_px.frame_address);
          mismatches++;
        end
        if (got_px.pixel_color !== want_px.pixel_color) begin
          $error("pixel_color expected %h actual %h",
                 want_px.pixel_color, got_px.pixel_color);
          mismatches++;
        end
      end
    end
    if ($urandom_range(0, 199) == 0) steady_rx = !steady_rx;
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!steady_rx && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    stim_row_t   directed[$];
    item_t       noise;
    int          goal;
    int          w;
    int          h;
    logic [31:0] cc;
    logic [31:0] fc;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_CEILING_COLOR;
    cfg_data <= '0;
    item_valid <= 1'b0;
    item <= '0;
    result_stall <= 1'b0;

    noise = rand_item();
    noise.cmd = CMD_UNUSED;
    directed.push_back(table_row(shade_cmd(0, 0), 1'b1, MAGENTA));
    directed.push_back(table_row(shade_cmd(767, 1023), 1'b1, 32'h0));
    directed.push_back(table_row(shade_cmd(768, 0), 1'b0, '0));
    directed.push_back(table_row(shade_cmd(1023, 1023), 1'b0, '0));
    directed.push_back(table_row(noise, 1'b0, '0));
    directed.push_back(table_row(load_cmd(2'd0, 0, 32'hFFFFFFFF), 1'b0, '0));
    directed.push_back(table_row(load_cmd(2'd0, 4095, 32'h0), 1'b0, '0));
    directed.push_back(table_row(begin_cmd(2'd0, -2048, 2047, -128, 32'h80000000,
                                           31'h7FFFFFFF), 1'b0, '0));
    directed.push_back(table_row(shade_cmd(0, 0), 1'b1, 32'hFFFFFFFF));
    directed.push_back(table_row(shade_cmd(1, 0), 1'b1, 32'hFFFFFFFF));
    directed.push_back(table_row(shade_cmd(2, 0), 1'b0, '0));
    directed.push_back(table_row(shade_cmd(3, 1023), 1'b0, '0));
    directed.push_back(table_row(begin_cmd(2'd3, 10, 20, 127, 32'h7FFFFFFF, 31'h0),
                                 1'b0, '0));
    directed.push_back(table_row(shade_cmd(9, 3), 1'b1, 32'h0));
    directed.push_back(table_row(shade_cmd(21, 3), 1'b1, 32'h0));
    directed.push_back(table_row(shade_cmd(10, 3), 1'b1, MAGENTA));
    directed.push_back(table_row(load_cmd(2'd3, 4095, 32'hA5A55A5A), 1'b0, '0));
    directed.push_back(table_row(shade_cmd(20, 3), 1'b1, 32'hA5A55A5A));
    directed.push_back(table_row(begin_cmd(2'd1, 2047, -2048, 0, 32'h0, 31'h0), 1'b0, '0));
    directed.push_back(table_row(shade_cmd(100, 7), 1'b1, 32'h0));
    directed.push_back(table_row(begin_cmd(2'd2, -2048, -1, 0, 32'h0, 31'h0), 1'b0, '0));
    directed.push_back(table_row(shade_cmd(0, 7), 1'b1, 32'h0));
    directed.push_back(table_row(begin_cmd(2'd2, 0, 767, 5, 32'h00010000, 31'h8000),
                                 1'b0, '0));
    directed.push_back(table_row(load_cmd(2'd2, 69, 32'h0F0F0F0F), 1'b0, '0));
    directed.push_back(table_row(shade_cmd(0, 1), 1'b1, 32'h0F0F0F0F));
    directed.push_back(table_row(shade_cmd(1, 1), 1'b1, 32'h0F0F0F0F));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      issue(directed[i].it);
      if (directed[i].fixed)
        expected_pixels[expected_pixels.size()-1].pixel_color = directed[i].color;
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      cc = $urandom;
      fc = $urandom;
      w = $urandom_range(0, 64);
      h = $urandom_range(0, 64);
      case (p)
        0: begin
          cc = 32'hFFFFFFFF;
          fc = 32'h0;
          w = 64;
          h = 64;
        end
        1: begin
          cc = 32'h0;
          fc = 32'hFFFFFFFF;
          w = 0;
          h = $urandom_range(1, 64);
        end
        2: begin
          w = 127;
          h = 127;
        end
        3: begin
          w = 1;
          h = 1;
        end
        4: begin
          w = $urandom_range(1, 16);
          h = $urandom_range(65, 127);
        end
        default: ;
      endcase
      write_reg(REG_CEILING_COLOR, cc);
      write_reg(REG_FLOOR_COLOR, fc);
      write_reg(REG_TEX_WIDTH, ($urandom & 32'hFFFFFF80) | 32'(w));
      write_reg(REG_TEX_HEIGHT, ($urandom & 32'hFFFFFF80) | 32'(h));
      goal = commands_sent + ITEMS_PER_PHASE;
      while (commands_sent < goal) random_step();
    end

    settle();
    if (mismatches == 0) begin
      $display("raycast_column_texture_shader_tb OK");
    end else begin
      $display("raycast_column_texture_shader_tb NOT OK");
    end
    $finish;
  end

endmodule
